>>> rtl/tdlm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdlm_pkg: shared types and constants of the two-wire display link master
// Sequencer phases, command codes and the hold length of each phase.
// ----------------------------------------------------------------------------
package tdlm_pkg;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned BIT_IDX_W     = $clog2(BITS_PER_BYTE);
    localparam int unsigned TICK_W        = 16;
    localparam int unsigned UNIT_W        = 3;

    localparam logic [TICK_W-1:0]    TICKS_RESET = 16'd32;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT    = BIT_IDX_W'(BITS_PER_BYTE - 1);

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_WRITE = 3'd3,
        ACT_READ  = 3'd4
    } action_t;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_ST_DIO  = 5'd1,
        PH_ST_CLK  = 5'd2,
        PH_SP_DIO  = 5'd3,
        PH_SP_CLK  = 5'd4,
        PH_SP_REL  = 5'd5,
        PH_WR_BIT  = 5'd6,
        PH_WR_HI   = 5'd7,
        PH_WR_LO   = 5'd8,
        PH_WR_REL  = 5'd9,
        PH_WR_AHI  = 5'd10,
        PH_WR_ALO  = 5'd11,
        PH_WR_END  = 5'd12,
        PH_RD_PRE  = 5'd13,
        PH_RD_HI   = 5'd14,
        PH_RD_LO   = 5'd15,
        PH_RD_POST = 5'd16,
        PH_RD_ACK  = 5'd17,
        PH_RD_AHI  = 5'd18,
        PH_RD_ALO  = 5'd19
    } phase_t;

    localparam logic [3:0] APB_REG_TICKS = 4'd0;

    // delay units a phase holds its drives for
    function automatic logic [UNIT_W-1:0] hold_units(input phase_t ph);
        logic [UNIT_W-1:0] u;
        unique case (ph)
            PH_IDLE:                          u = 3'd0;
            PH_WR_REL, PH_WR_END,
            PH_RD_PRE, PH_RD_POST:            u = 3'd3;
            PH_RD_LO:                         u = 3'd5;
            default:                          u = 3'd1;
        endcase
        return u;
    endfunction

endpackage

>>> rtl/two_wire_display_link_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_wire_display_link_master: tick-driven two-wire display link master
// Runs start, stop, write-byte and read-byte sequences on a clock line and an
// open-drain data line, one request per line tick.
// ----------------------------------------------------------------------------
// Each request on the cmd channel is one line tick and yields exactly one
// result on the res channel, computed in the cycle the request is taken and
// held in the result register. A request can be taken every clock cycle; the
// only thing that holds cmd_ready low is a result still waiting in the result
// register while res_ready is low. Line timing is counted in ticks: every
// phase lasts a whole number of delay units of ticks_per_delay_unit ticks
// (register 0, reset 32, 0 behaves as 1). Commands given while a sequence
// runs are dropped and flagged by rejected.
module two_wire_display_link_master
    import tdlm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [2:0]  action,
    input  logic [7:0]  data_byte,
    input  logic        dio_in,

    output logic        res_valid,
    input  logic        res_ready,
    output logic        clk_level,
    output logic        dio_level,
    output logic        busy_res,
    output logic        read_valid,
    output logic [7:0]  read_byte,
    output logic        rejected,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [TICK_W-1:0]    ticks_reg;
    phase_t               phase_reg, phase_next;
    logic [BIT_IDX_W-1:0] bit_count_reg, bit_count_next;
    logic [7:0]           shift_byte_reg, shift_byte_next;
    logic [UNIT_W-1:0]    unit_count_reg, unit_count_next;
    logic [TICK_W-1:0]    tick_count_reg, tick_count_next;
    logic                 clk_drive_reg, clk_drive_next;
    logic                 dio_drive_reg, dio_drive_next;
    logic [7:0]           last_read_reg, last_read_next;

    logic                 res_valid_reg;
    logic                 clk_level_reg, dio_level_reg, busy_res_reg;
    logic                 read_valid_reg, rejected_reg;
    logic [7:0]           read_byte_reg;

    logic                 take;
    logic                 valid_now, rej_now;
    logic                 do_enter, do_finish;
    phase_t               enter_ph;
    logic [TICK_W-1:0]    unit_ticks;
    logic                 cfg_write;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == APB_REG_TICKS[0]);
    assign prdata    = (paddr[2] == APB_REG_TICKS[0]) ? {16'd0, ticks_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= TICKS_RESET;
        end
        else if (cfg_write)
        begin
            ticks_reg <= pwdata[TICK_W-1:0];
        end
    end

    assign unit_ticks = (ticks_reg == '0) ? TICK_W'(1) : ticks_reg;

    // ------------------------------------------------------------------
    // sequencer, one tick per accepted request
    // ------------------------------------------------------------------
    assign cmd_ready = !res_valid_reg || res_ready;
    assign take      = cmd_valid && cmd_ready;

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_byte_next = shift_byte_reg;
        unit_count_next = unit_count_reg;
        tick_count_next = tick_count_reg;
        clk_drive_next  = clk_drive_reg;
        dio_drive_next  = dio_drive_reg;
        last_read_next  = last_read_reg;
        valid_now       = 1'b0;
        rej_now         = 1'b0;
        do_enter        = 1'b0;
        do_finish       = 1'b0;
        enter_ph        = PH_IDLE;

        if (take)
        begin
            if (phase_reg != PH_IDLE)
            begin
                rej_now = (action != ACT_NONE);
                if (tick_count_reg > TICK_W'(1))
                begin
                    tick_count_next = tick_count_reg - TICK_W'(1);
                end
                else
                begin
                    tick_count_next = unit_ticks;
                    if (unit_count_reg > UNIT_W'(1))
                    begin
                        unit_count_next = unit_count_reg - UNIT_W'(1);
                    end
                    else
                    begin
                        do_enter = 1'b1;
                        unique case (phase_reg)
                            PH_ST_DIO:  enter_ph = PH_ST_CLK;
                            PH_SP_DIO:  enter_ph = PH_SP_CLK;
                            PH_SP_CLK:  enter_ph = PH_SP_REL;
                            PH_WR_BIT:  enter_ph = PH_WR_HI;
                            PH_WR_HI:   enter_ph = PH_WR_LO;
                            PH_WR_LO:
                            begin
                                if (bit_count_reg == LAST_BIT)
                                begin
                                    enter_ph = PH_WR_REL;
                                end
                                else
                                begin
                                    bit_count_next = bit_count_reg + BIT_IDX_W'(1);
                                    enter_ph       = PH_WR_BIT;
                                end
                            end
                            PH_WR_REL:  enter_ph = PH_WR_AHI;
                            PH_WR_AHI:  enter_ph = PH_WR_ALO;
                            PH_WR_ALO:  enter_ph = PH_WR_END;
                            PH_RD_PRE:  enter_ph = PH_RD_HI;
                            PH_RD_HI:
                            begin
                                shift_byte_next = {shift_byte_reg[6:0], dio_in};
                                enter_ph        = PH_RD_LO;
                            end
                            PH_RD_LO:
                            begin
                                if (bit_count_reg == LAST_BIT)
                                begin
                                    enter_ph = PH_RD_POST;
                                end
                                else
                                begin
                                    bit_count_next = bit_count_reg + BIT_IDX_W'(1);
                                    enter_ph       = PH_RD_HI;
                                end
                            end
                            PH_RD_POST: enter_ph = PH_RD_ACK;
                            PH_RD_ACK:  enter_ph = PH_RD_AHI;
                            PH_RD_AHI:  enter_ph = PH_RD_ALO;
                            default:
                            begin
                                do_enter  = 1'b0;
                                do_finish = 1'b1;
                            end
                        endcase
                    end
                end
            end
            else
            begin
                bit_count_next = '0;
                do_enter       = 1'b1;
                unique case (action)
                    ACT_START: enter_ph = PH_ST_DIO;
                    ACT_STOP:  enter_ph = PH_SP_DIO;
                    ACT_WRITE:
                    begin
                        shift_byte_next = data_byte;
                        enter_ph        = PH_WR_BIT;
                    end
                    ACT_READ:
                    begin
                        shift_byte_next = '0;
                        enter_ph        = PH_RD_PRE;
                    end
                    default:   do_enter = 1'b0;
                endcase
            end
        end

        if (do_finish)
        begin
            if (phase_reg == PH_WR_END || phase_reg == PH_RD_ALO)
            begin
                dio_drive_next = 1'b1;
            end
            if (phase_reg == PH_RD_ALO)
            begin
                last_read_next = shift_byte_reg;
                valid_now      = 1'b1;
            end
            phase_next      = PH_IDLE;
            unit_count_next = '0;
            tick_count_next = '0;
        end

        if (do_enter)
        begin
            phase_next      = enter_ph;
            unit_count_next = hold_units(enter_ph);
            tick_count_next = unit_ticks;
            unique case (enter_ph)
                PH_ST_DIO, PH_SP_DIO, PH_RD_ACK:
                    dio_drive_next = 1'b0;
                PH_ST_CLK, PH_WR_LO, PH_WR_ALO, PH_RD_LO, PH_RD_ALO:
                    clk_drive_next = 1'b0;
                PH_SP_CLK, PH_WR_HI, PH_WR_AHI, PH_RD_HI, PH_RD_AHI:
                    clk_drive_next = 1'b1;
                PH_SP_REL, PH_WR_REL:
                    dio_drive_next = 1'b1;
                PH_WR_BIT:
                    dio_drive_next = shift_byte_next[bit_count_next];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            shift_byte_reg <= '0;
            unit_count_reg <= '0;
            tick_count_reg <= '0;
            clk_drive_reg  <= 1'b1;
            dio_drive_reg  <= 1'b1;
            last_read_reg  <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            shift_byte_reg <= shift_byte_next;
            unit_count_reg <= unit_count_next;
            tick_count_reg <= tick_count_next;
            clk_drive_reg  <= clk_drive_next;
            dio_drive_reg  <= dio_drive_next;
            last_read_reg  <= last_read_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            clk_level_reg  <= clk_drive_next;
            dio_level_reg  <= dio_drive_next;
            busy_res_reg   <= (phase_next != PH_IDLE);
            read_valid_reg <= valid_now;
            read_byte_reg  <= last_read_next;
            rejected_reg   <= rej_now;
        end
    end

    assign res_valid  = res_valid_reg;
    assign clk_level  = clk_level_reg;
    assign dio_level  = dio_level_reg;
    assign busy_res   = busy_res_reg;
    assign read_valid = read_valid_reg;
    assign read_byte  = read_byte_reg;
    assign rejected   = rejected_reg;

endmodule

>>> rtl/tdlm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdlm_checker: port-level checks for the two-wire display link master
// Watches the result channel and the line levels it reports.
// ----------------------------------------------------------------------------
module tdlm_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic       clk_level,
    input logic       dio_level,
    input logic       busy_res,
    input logic       read_valid,
    input logic [7:0] read_byte
);

    // a completed read ends the sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && read_valid |-> !busy_res)
        else $error("read completed while still busy");

    // read ends with clock low and data released
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && read_valid |-> !clk_level && dio_level)
        else $error("bad line levels at read completion");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(read_byte) && $stable(busy_res))
        else $error("result changed while stalled");

endmodule

bind two_wire_display_link_master tdlm_checker u_tdlm_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .clk_level  (clk_level),
    .dio_level  (dio_level),
    .busy_res   (busy_res),
    .read_valid (read_valid),
    .read_byte  (read_byte)
);

>>> tb/sv/two_wire_display_link_master_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_wire_display_link_master_test: self-checking bench for the link master
// Drives one line tick per request and predicts clock line, data line, busy,
// read completion and reject flags for every tick. Covers each command, idle
// and busy misuse, and delay units from zero up to long holds, with random
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module two_wire_display_link_master_test;
    import tdlm_pkg::*;

    localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
    localparam logic [2:0] TOP_BIT       = 3'd7;
    localparam logic [2:0] TICKS_ADDR    = 3'(APB_REG_TICKS * 4);

    typedef enum int unsigned {
        DIN_LOW,
        DIN_HIGH,
        DIN_RANDOM
    } din_src_t;

    typedef struct packed {
        logic       clk_lvl;
        logic       dio_lvl;
        logic       busy;
        logic       rd_done;
        logic [7:0] rd_byte;
        logic       rej;
    } line_res_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    logic [2:0]  action    = ACT_NONE;
    logic [7:0]  data_byte = 8'h00;
    logic        dio_in    = 1'b1;
    logic        res_valid;
    logic        res_ready = 1'b1;
    logic        clk_level;
    logic        dio_level;
    logic        busy_res;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic        rejected;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    // sequencer copy used for prediction
    phase_t      seq_phase     = PH_IDLE;
    logic [2:0]  seq_bit       = '0;
    logic [7:0]  seq_shift     = '0;
    logic [2:0]  seq_units     = '0;
    logic [15:0] seq_ticks     = '0;
    logic        drv_clk       = 1'b1;
    logic        drv_dio       = 1'b1;
    logic [7:0]  seq_last_read = '0;
    logic [15:0] unit_cfg      = 16'd32;

    line_res_t   predicted_lines[$];
    int unsigned mismatches = 0;
    int unsigned burst_left = 0;
    bit          gaps_on    = 1'b1;
    bit          stalls_on  = 1'b1;

    two_wire_display_link_master u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .action     (action),
        .data_byte  (data_byte),
        .dio_in     (dio_in),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .clk_level  (clk_level),
        .dio_level  (dio_level),
        .busy_res   (busy_res),
        .read_valid (read_valid),
        .read_byte  (read_byte),
        .rejected   (rejected),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("** two_wire_display_link_master: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Line sequencer prediction
    // ------------------------------------------------------------------
    function automatic logic [15:0] ticks_per_unit();
        return (unit_cfg == 16'd0) ? 16'd1 : unit_cfg;
    endfunction

    function automatic logic [2:0] phase_units(phase_t p);
        case (p)
            PH_IDLE:                                     return 3'd0;
            PH_WR_REL, PH_WR_END, PH_RD_PRE, PH_RD_POST: return 3'd3;
            PH_RD_LO:                                    return 3'd5;
            default:                                     return 3'd1;
        endcase
    endfunction

    function automatic void seq_enter(phase_t p);
        seq_phase = p;
        seq_units = phase_units(p);
        seq_ticks = ticks_per_unit();
        case (p)
            PH_ST_DIO, PH_SP_DIO, PH_RD_ACK:                     drv_dio = 1'b0;
            PH_ST_CLK, PH_WR_LO, PH_WR_ALO, PH_RD_LO, PH_RD_ALO: drv_clk = 1'b0;
            PH_SP_CLK, PH_WR_HI, PH_WR_AHI, PH_RD_HI, PH_RD_AHI: drv_clk = 1'b1;
            PH_SP_REL, PH_WR_REL:                                drv_dio = 1'b1;
            PH_WR_BIT:                                           drv_dio = seq_shift[seq_bit];
            default: ;
        endcase
    endfunction

    function automatic line_res_t predict_tick(logic [2:0] act, logic [7:0] db, logic din);
        line_res_t r;
        logic      done;
        done  = 1'b0;
        r.rej = 1'b0;
        if (seq_phase != PH_IDLE)
        begin
            // anything but a plain tick is refused, even on the finishing tick
            r.rej = (act != ACT_NONE);
            if (seq_ticks > 16'd1)
                seq_ticks--;
            else
            begin
                seq_ticks = ticks_per_unit();
                if (seq_units > 3'd1)
                    seq_units--;
                else
                begin
                    case (seq_phase)
                        PH_ST_DIO:  seq_enter(PH_ST_CLK);
                        PH_SP_DIO:  seq_enter(PH_SP_CLK);
                        PH_SP_CLK:  seq_enter(PH_SP_REL);
                        PH_WR_BIT:  seq_enter(PH_WR_HI);
                        PH_WR_HI:   seq_enter(PH_WR_LO);
                        PH_WR_LO:
                        begin
                            if (seq_bit == TOP_BIT)
                                seq_enter(PH_WR_REL);
                            else
                            begin
                                seq_bit++;
                                seq_enter(PH_WR_BIT);
                            end
                        end
                        PH_WR_REL:  seq_enter(PH_WR_AHI);
                        PH_WR_AHI:  seq_enter(PH_WR_ALO);
                        PH_WR_ALO:  seq_enter(PH_WR_END);
                        PH_RD_PRE:  seq_enter(PH_RD_HI);
                        PH_RD_HI:
                        begin
                            seq_shift = {seq_shift[6:0], din};
                            seq_enter(PH_RD_LO);
                        end
                        PH_RD_LO:
                        begin
                            if (seq_bit == TOP_BIT)
                                seq_enter(PH_RD_POST);
                            else
                            begin
                                seq_bit++;
                                seq_enter(PH_RD_HI);
                            end
                        end
                        PH_RD_POST: seq_enter(PH_RD_ACK);
                        PH_RD_ACK:  seq_enter(PH_RD_AHI);
                        PH_RD_AHI:  seq_enter(PH_RD_ALO);
                        default:
                        begin
                            // last segment ran out: release data after a write or read, latch a read
                            if (seq_phase == PH_WR_END || seq_phase == PH_RD_ALO)
                                drv_dio = 1'b1;
                            if (seq_phase == PH_RD_ALO)
                            begin
                                seq_last_read = seq_shift;
                                done          = 1'b1;
                            end
                            seq_phase = PH_IDLE;
                            seq_units = '0;
                            seq_ticks = '0;
                        end
                    endcase
                end
            end
        end
        else
        begin
            seq_bit = '0;
            case (act)
                ACT_START: seq_enter(PH_ST_DIO);
                ACT_STOP:  seq_enter(PH_SP_DIO);
                ACT_WRITE:
                begin
                    seq_shift = db;
                    seq_enter(PH_WR_BIT);
                end
                ACT_READ:
                begin
                    seq_shift = '0;
                    seq_enter(PH_RD_PRE);
                end
                default: ;
            endcase
        end
        r.clk_lvl = drv_clk;
        r.dio_lvl = drv_dio;
        r.busy    = (seq_phase != PH_IDLE);
        r.rd_done = done;
        r.rd_byte = seq_last_read;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    function automatic logic pick_din(din_src_t src);
        case (src)
            DIN_LOW:  return 1'b0;
            DIN_HIGH: return 1'b1;
            default:  return 1'($urandom);
        endcase
    endfunction

    function automatic logic [2:0] any_command();
        return 3'($urandom_range(ACT_START, ACT_UNUSED_HI));
    endfunction

    // called and returns at a falling edge
    task automatic send_tick(logic [2:0] act, logic [7:0] db, logic din);
        int unsigned pause;
        if (gaps_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 60);
            pause      = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (pause != 0)
            begin
                cmd_valid <= 1'b0;
                repeat (pause) @(negedge clk);
            end
        end
        if (burst_left != 0)
            burst_left--;
        cmd_valid <= 1'b1;
        action    <= act;
        data_byte <= db;
        dio_in    <= din;
        @(posedge clk);
        while (cmd_ready !== 1'b1)
            @(posedge clk);
        predicted_lines.push_back(predict_tick(act, db, din));
        @(negedge clk);
    endtask

    task automatic finish_sequence(din_src_t src, int unsigned noise_pct);
        logic [2:0] act;
        while (seq_phase != PH_IDLE)
        begin
            act = ($urandom_range(1, 100) <= noise_pct) ? any_command() : ACT_NONE;
            send_tick(act, 8'($urandom), pick_din(src));
        end
    endtask

    task automatic run_command(logic [2:0] act, logic [7:0] db, din_src_t src,
                               int unsigned noise_pct);
        send_tick(act, db, pick_din(src));
        finish_sequence(src, noise_pct);
    endtask

    // hold off requests until every outstanding result is back
    task automatic drain();
        cmd_valid <= 1'b0;
        while (predicted_lines.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_delay_unit(logic [15:0] ticks);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TICKS_ADDR;
        pwdata  <= {16'($urandom), ticks};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        unit_cfg = ticks;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    initial
    begin : stall_pattern
        int unsigned mode;
        int unsigned left;
        mode = 0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(16, 96);
            end
            left--;
            if (!stalls_on)
                res_ready <= 1'b1;
            else
                case (mode)
                    0:       res_ready <= 1'b1;
                    1:       res_ready <= ($urandom_range(0, 2) != 0);
                    2:       res_ready <= ((left % 7) < 3);
                    default: res_ready <= ($urandom_range(0, 7) == 0);
                endcase
        end
    end

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin : result_check
        line_res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_valid === 1'b1 && res_ready === 1'b1)
            begin
                if (predicted_lines.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = predicted_lines.pop_front();
                    check_field("clk_level", want.clk_lvl, clk_level);
                    check_field("dio_level", want.dio_lvl, dio_level);
                    check_field("busy_res", want.busy, busy_res);
                    check_field("read_valid", want.rd_done, read_valid);
                    check_field("read_byte", want.rd_byte, read_byte);
                    check_field("rejected", want.rej, rejected);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_delay_unit();
        run_command(ACT_START, 8'($urandom), DIN_RANDOM, 0);
        run_command(ACT_STOP, 8'($urandom), DIN_RANDOM, 0);
    endtask

    task automatic test_write_bytes();
        set_delay_unit(16'd1);
        run_command(ACT_WRITE, 8'h00, DIN_RANDOM, 0);
        run_command(ACT_WRITE, 8'hFF, DIN_RANDOM, 0);
        run_command(ACT_WRITE, 8'hA5, DIN_RANDOM, 0);
        run_command(ACT_WRITE, 8'h5A, DIN_RANDOM, 0);
    endtask

    task automatic test_read_bytes();
        run_command(ACT_READ, 8'($urandom), DIN_HIGH, 0);
        run_command(ACT_READ, 8'($urandom), DIN_LOW, 0);
        run_command(ACT_READ, 8'($urandom), DIN_RANDOM, 0);
    endtask

    task automatic test_idle_actions();
        logic [2:0] act;
        send_tick(ACT_NONE, 8'($urandom), pick_din(DIN_RANDOM));
        for (act = ACT_UNUSED_LO; act != ACT_NONE; act++)
            send_tick(act, 8'($urandom), pick_din(DIN_RANDOM));
        send_tick(ACT_NONE, 8'($urandom), pick_din(DIN_RANDOM));
    endtask

    task automatic test_busy_commands();
        set_delay_unit(16'd2);
        // on the stop and start runs every busy tick carries a command, the finishing tick too
        run_command(ACT_STOP, 8'($urandom), DIN_RANDOM, 100);
        run_command(ACT_WRITE, 8'($urandom), DIN_RANDOM, 25);
        run_command(ACT_READ, 8'($urandom), DIN_RANDOM, 25);
        run_command(ACT_START, 8'($urandom), DIN_RANDOM, 100);
    endtask

    task automatic test_zero_delay_unit();
        set_delay_unit(16'd0);
        run_command(ACT_START, 8'($urandom), DIN_RANDOM, 0);
        run_command(ACT_WRITE, 8'($urandom), DIN_RANDOM, 10);
        run_command(ACT_READ, 8'($urandom), DIN_RANDOM, 10);
    endtask

    task automatic test_long_delay_unit();
        set_delay_unit(16'd40);
        // long hold: run flat out to keep the run short
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_command(ACT_START, 8'($urandom), DIN_RANDOM, 1);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic run_random(int unsigned count);
        int unsigned sent;
        int unsigned pick;
        logic [2:0]  act;
        for (sent = 0; sent < count; sent++)
        begin
            pick = $urandom_range(0, 99);
            if (seq_phase != PH_IDLE)
                act = (pick < 5) ? any_command() : ACT_NONE;
            else if (pick < 10)
                act = ACT_START;
            else if (pick < 20)
                act = ACT_STOP;
            else if (pick < 55)
                act = ACT_WRITE;
            else if (pick < 88)
                act = ACT_READ;
            else if (pick < 94)
                act = ACT_NONE;
            else
                act = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
            send_tick(act, 8'($urandom), pick_din(DIN_RANDOM));
        end
        finish_sequence(DIN_RANDOM, 5);
    endtask

    task automatic test_random_traffic();
        logic [15:0] unit_list [0:4];
        int          i;
        unit_list[0] = 16'd1;
        unit_list[1] = 16'd2;
        unit_list[2] = 16'd3;
        unit_list[3] = 16'd0;
        unit_list[4] = 16'($urandom_range(1, 6));
        for (i = 0; i < 5; i++)
        begin
            set_delay_unit(unit_list[i]);
            run_random(40);
        end
    endtask

    initial
    begin : stimulus
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_delay_unit();
        test_idle_actions();
        test_write_bytes();
        test_read_bytes();
        test_busy_commands();
        test_zero_delay_unit();
        test_long_delay_unit();
        test_random_traffic();

        drain();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("** two_wire_display_link_master: PASSED **");
        else
            $display("** two_wire_display_link_master: FAILED **");
        $finish;
    end

endmodule
